// ===== rtl/tlqv_pkg.sv =====
package tlqv_pkg;

   // field widths
   localparam int CoordW = 24;
   localparam int WidthW = 16;
   localparam int ColorW = 32;
   localparam int CfgW   = 13;
   localparam int OutW   = 20;
   localparam int IdxW   = 3;

   // internal widths
   localparam int DiffW  = 24;   // magnitude of a coordinate difference
   localparam int SqW    = 48;   // square of a difference
   localparam int ProdW  = 40;   // difference times stroke width
   localparam int RadW   = 64;   // radicand of the length root
   localparam int SqrtW  = 32;   // segment length, Q15
   localparam int RemW   = 33;   // root remainder
   localparam int OffDW  = 32;   // offset divisor
   localparam int OffQW  = 28;   // offset quotient, clamped at 2^27
   localparam int OffW   = 29;   // signed offset
   localparam int PosW   = 30;   // signed vertex position, Q8 pixels
   localparam int MapDW  = 13;   // mapping divisor
   localparam int MapQW  = 22;   // mapping quotient, clamped at 2^21

   localparam logic [IdxW-1:0] LastIdx = 3'd5;
   localparam logic signed [OutW-1:0] TexX = -20'sd65536;
   localparam logic signed [OutW-1:0] TexY = 20'sd65536;
   localparam logic signed [24:0] QOne = 25'sd65536;
   localparam logic signed [24:0] SatMax = 25'sd524287;
   localparam logic signed [24:0] SatMin = -25'sd524288;
   localparam logic [CfgW-1:0] CanvasReset = 13'd1024;

   // primitive kinds
   localparam logic CmdRect = 1'b0;
   localparam logic CmdLine = 1'b1;

   // register indexes
   localparam logic RegWidth  = 1'b0;
   localparam logic RegHeight = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic signed [CoordW-1:0] x0;
      logic signed [CoordW-1:0] y0;
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic [ColorW-1:0]        color;
   } tlqv_prim_type;

   typedef struct packed {
      tlqv_prim_type    prim;
      logic             neg_x;
      logic             neg_y;
      logic [ProdW-1:0] prod_x;
      logic [ProdW-1:0] prod_y;
   } tlqv_geom_type;

   typedef struct packed {
      tlqv_prim_type          prim;
      logic signed [OffW-1:0] ox;
      logic signed [OffW-1:0] oy;
   } tlqv_quad_type;

   typedef struct packed {
      logic [ColorW-1:0] color;
      logic [IdxW-1:0]   idx;
   } tlqv_vtx_type;

endpackage

// ===== rtl/tlqv_div_pipe.sv =====
module tlqv_div_pipe #(
   parameter int DW = 13,
   parameter int QW = 22,
   parameter int TW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DW+QW-1:0] in_num,
   input  logic [DW-1:0]    in_den,
   input  logic [TW-1:0]    in_tag,
   output logic             out_valid,
   output logic [QW-1:0]    out_quot,
   output logic [TW-1:0]    out_tag
);

   // one quotient bit per stage; numerator low bits shift out as quotient bits shift in
   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] lq_ff    [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [TW-1:0] tag_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic          valid_src;
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] lq_src;
      logic [TW-1:0] tag_src;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] lq_in;

      if (i == 0) begin : g_head
         assign valid_src = in_valid;
         assign rem_src   = in_num[DW+QW-1:QW];
         assign lq_src    = in_num[QW-1:0];
         assign den_src   = in_den;
         assign tag_src   = in_tag;
      end else begin : g_body
         assign valid_src = valid_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign lq_src    = lq_ff[i-1];
         assign den_src   = den_ff[i-1];
         assign tag_src   = tag_ff[i-1];
      end

      // restoring step
      assign trial  = {rem_src, lq_src[QW-1]};
      assign diff   = trial - {1'b0, den_src};
      assign ge     = trial >= {1'b0, den_src};
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      assign lq_in  = {lq_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            lq_ff[i]  <= lq_in;
            den_ff[i] <= den_src;
            tag_ff[i] <= tag_src;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = lq_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

// ===== rtl/tlqv_isqrt_pipe.sv =====
module tlqv_isqrt_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [tlqv_pkg::RadW-1:0] in_rad,
   input  tlqv_pkg::tlqv_geom_type in_geom,
   output logic                    out_valid,
   output logic [tlqv_pkg::SqrtW-1:0] out_root,
   output tlqv_pkg::tlqv_geom_type out_geom
);

   localparam int N = tlqv_pkg::SqrtW;

   // one root bit per stage, two radicand bits consumed per stage
   logic                        valid_ff [N];
   logic [tlqv_pkg::RemW-1:0]   rem_ff   [N];
   logic [N-1:0]                root_ff  [N];
   logic [tlqv_pkg::RadW-1:0]   rad_ff   [N];
   tlqv_pkg::tlqv_geom_type     geom_ff  [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                      valid_src;
      logic [tlqv_pkg::RemW-1:0] rem_src;
      logic [N-1:0]              root_src;
      logic [tlqv_pkg::RadW-1:0] rad_src;
      tlqv_pkg::tlqv_geom_type   geom_src;
      logic [tlqv_pkg::RemW+1:0] acc;
      logic [tlqv_pkg::RemW+1:0] trial;
      logic [tlqv_pkg::RemW+1:0] diff;
      logic                      ge;
      logic [tlqv_pkg::RemW-1:0] rem_in;
      logic [N-1:0]              root_in;
      logic [tlqv_pkg::RadW-1:0] rad_in;

      if (i == 0) begin : g_head
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign rad_src   = in_rad;
         assign geom_src  = in_geom;
      end else begin : g_body
         assign valid_src = valid_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign root_src  = root_ff[i-1];
         assign rad_src   = rad_ff[i-1];
         assign geom_src  = geom_ff[i-1];
      end

      // trial subtract of 4*root+1
      assign acc     = {rem_src, rad_src[tlqv_pkg::RadW-1:tlqv_pkg::RadW-2]};
      assign trial   = {1'b0, root_src, 2'b01};
      assign diff    = acc - trial;
      assign ge      = acc >= trial;
      assign rem_in  = ge ? diff[tlqv_pkg::RemW-1:0] : acc[tlqv_pkg::RemW-1:0];
      assign root_in = {root_src[N-2:0], ge};
      assign rad_in  = {rad_src[tlqv_pkg::RadW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= rad_in;
            geom_ff[i] <= geom_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_geom  = geom_ff[N-1];

endmodule

// ===== rtl/tlqv_offset.sv =====
module tlqv_offset (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  tlqv_pkg::tlqv_prim_type     in_prim,
   input  logic [tlqv_pkg::WidthW-1:0] in_width,
   output logic                        out_valid,
   output tlqv_pkg::tlqv_quad_type     out_quad
);

   localparam int PrimW = $bits(tlqv_pkg::tlqv_prim_type);
   localparam int NumW  = tlqv_pkg::OffDW + tlqv_pkg::OffQW;
   localparam int LimW  = tlqv_pkg::OffDW + tlqv_pkg::OffQW - 1;

   // stage 1: differences and their magnitudes
   logic signed [tlqv_pkg::DiffW:0] dx;
   logic signed [tlqv_pkg::DiffW:0] dy;
   logic [tlqv_pkg::DiffW:0]        dx_neg;
   logic [tlqv_pkg::DiffW:0]        dy_neg;
   logic                            s1_valid_ff;
   tlqv_pkg::tlqv_prim_type         s1_prim_ff;
   logic [tlqv_pkg::WidthW-1:0]     s1_w_ff;
   logic [tlqv_pkg::DiffW-1:0]      s1_adx_ff;
   logic [tlqv_pkg::DiffW-1:0]      s1_ady_ff;
   logic                            s1_ndx_ff;
   logic                            s1_ndy_ff;

   assign dx     = $signed({in_prim.x1[tlqv_pkg::CoordW-1], in_prim.x1})
                 - $signed({in_prim.x0[tlqv_pkg::CoordW-1], in_prim.x0});
   assign dy     = $signed({in_prim.y1[tlqv_pkg::CoordW-1], in_prim.y1})
                 - $signed({in_prim.y0[tlqv_pkg::CoordW-1], in_prim.y0});
   assign dx_neg = -dx;
   assign dy_neg = -dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prim_ff <= in_prim;
         s1_w_ff    <= in_width;
         s1_adx_ff  <= dx[tlqv_pkg::DiffW] ? dx_neg[tlqv_pkg::DiffW-1:0] : dx[tlqv_pkg::DiffW-1:0];
         s1_ady_ff  <= dy[tlqv_pkg::DiffW] ? dy_neg[tlqv_pkg::DiffW-1:0] : dy[tlqv_pkg::DiffW-1:0];
         s1_ndx_ff  <= dx[tlqv_pkg::DiffW];
         s1_ndy_ff  <= dy[tlqv_pkg::DiffW];
      end
   end

   // stage 2: squares and width products
   logic                       s2_valid_ff;
   tlqv_pkg::tlqv_prim_type    s2_prim_ff;
   logic [tlqv_pkg::SqW-1:0]   s2_sqx_ff;
   logic [tlqv_pkg::SqW-1:0]   s2_sqy_ff;
   logic [tlqv_pkg::ProdW-1:0] s2_px_ff;
   logic [tlqv_pkg::ProdW-1:0] s2_py_ff;
   logic                       s2_negx_ff;
   logic                       s2_negy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_prim_ff <= s1_prim_ff;
         s2_sqx_ff  <= s1_adx_ff * s1_adx_ff;
         s2_sqy_ff  <= s1_ady_ff * s1_ady_ff;
         s2_px_ff   <= s1_ady_ff * s1_w_ff;
         s2_py_ff   <= s1_adx_ff * s1_w_ff;
         s2_negx_ff <= s1_ndy_ff;
         s2_negy_ff <= s1_ndx_ff;
      end
   end

   // stage 3: radicand, squared length in Q30
   logic [tlqv_pkg::SqW:0]     sum_sq;
   logic                       s3_valid_ff;
   logic [tlqv_pkg::RadW-1:0]  s3_rad_ff;
   tlqv_pkg::tlqv_geom_type    s3_geom_ff;

   assign sum_sq = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_rad_ff         <= {1'b0, sum_sq, 14'b0};
         s3_geom_ff.prim   <= s2_prim_ff;
         s3_geom_ff.neg_x  <= s2_negx_ff;
         s3_geom_ff.neg_y  <= s2_negy_ff;
         s3_geom_ff.prod_x <= s2_px_ff;
         s3_geom_ff.prod_y <= s2_py_ff;
      end
   end

   // segment length
   logic                       sq_valid;
   logic [tlqv_pkg::SqrtW-1:0] sq_root;
   tlqv_pkg::tlqv_geom_type    sq_geom;

   tlqv_isqrt_pipe u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_rad_ff),
      .in_geom   (s3_geom_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_geom  (sq_geom)
   );

   // stage 4: rounded numerators, clamped so the quotient stays below 2^27+1
   logic                       off_zero;
   logic [LimW-1:0]            lim;
   logic [LimW-1:0]            sum_x;
   logic [LimW-1:0]            sum_y;
   logic [LimW-1:0]            clip_x;
   logic [LimW-1:0]            clip_y;
   logic                       s4_valid_ff;
   logic [NumW-1:0]            s4_numx_ff;
   logic [NumW-1:0]            s4_numy_ff;
   logic [tlqv_pkg::OffDW-1:0] s4_den_ff;
   tlqv_pkg::tlqv_prim_type    s4_prim_ff;
   logic                       s4_negx_ff;
   logic                       s4_negy_ff;

   assign off_zero = (sq_root == '0) || (sq_geom.prim.cmd == tlqv_pkg::CmdRect);
   assign lim      = {sq_root, {(tlqv_pkg::OffQW-1){1'b0}}};
   assign sum_x    = LimW'({sq_geom.prod_x, 7'b0}) + LimW'(sq_root[tlqv_pkg::SqrtW-1:1]);
   assign sum_y    = LimW'({sq_geom.prod_y, 7'b0}) + LimW'(sq_root[tlqv_pkg::SqrtW-1:1]);
   assign clip_x   = (sum_x >= lim) ? lim : sum_x;
   assign clip_y   = (sum_y >= lim) ? lim : sum_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_numx_ff <= off_zero ? '0 : {1'b0, clip_x};
         s4_numy_ff <= off_zero ? '0 : {1'b0, clip_y};
         s4_den_ff  <= (sq_root == '0) ? tlqv_pkg::OffDW'(1) : sq_root;
         s4_prim_ff <= sq_geom.prim;
         s4_negx_ff <= sq_geom.neg_x;
         s4_negy_ff <= sq_geom.neg_y;
      end
   end

   // offset dividers
   logic                       dvx_valid;
   logic [tlqv_pkg::OffQW-1:0] dvx_quot;
   logic [PrimW:0]             dvx_tag;
   logic                       dvy_valid;
   logic [tlqv_pkg::OffQW-1:0] dvy_quot;
   logic                       dvy_tag;

   tlqv_div_pipe #(
      .DW (tlqv_pkg::OffDW),
      .QW (tlqv_pkg::OffQW),
      .TW (PrimW + 1)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_numx_ff),
      .in_den    (s4_den_ff),
      .in_tag    ({s4_prim_ff, s4_negx_ff}),
      .out_valid (dvx_valid),
      .out_quot  (dvx_quot),
      .out_tag   (dvx_tag)
   );

   tlqv_div_pipe #(
      .DW (tlqv_pkg::OffDW),
      .QW (tlqv_pkg::OffQW),
      .TW (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_numy_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_negy_ff),
      .out_valid (dvy_valid),
      .out_quot  (dvy_quot),
      .out_tag   (dvy_tag)
   );

   // stage 5: signed offsets
   logic signed [tlqv_pkg::OffW-1:0] ox_mag;
   logic signed [tlqv_pkg::OffW-1:0] oy_mag;
   logic                             s5_valid_ff;
   tlqv_pkg::tlqv_quad_type          s5_quad_ff;

   assign ox_mag = $signed({1'b0, dvx_quot});
   assign oy_mag = $signed({1'b0, dvy_quot});

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= dvx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_quad_ff.prim <= dvx_tag[PrimW:1];
         s5_quad_ff.ox   <= dvx_tag[0] ? -ox_mag : ox_mag;
         s5_quad_ff.oy   <= dvy_tag ? -oy_mag : oy_mag;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_quad  = s5_quad_ff;

   // y divider runs in lockstep with x divider
   logic unused_dvy_valid;
   assign unused_dvy_valid = dvy_valid;

endmodule

// ===== rtl/tlqv_map.sv =====
module tlqv_map (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [tlqv_pkg::PosW-1:0] in_px,
   input  logic signed [tlqv_pkg::PosW-1:0] in_py,
   input  tlqv_pkg::tlqv_vtx_type           in_vtx,
   input  logic [tlqv_pkg::CfgW-1:0]        canvas_width,
   input  logic [tlqv_pkg::CfgW-1:0]        canvas_height,
   output logic                             out_valid,
   output logic signed [tlqv_pkg::OutW-1:0] out_x,
   output logic signed [tlqv_pkg::OutW-1:0] out_y,
   output tlqv_pkg::tlqv_vtx_type           out_vtx
);

   localparam int VtxW  = $bits(tlqv_pkg::tlqv_vtx_type);
   localparam int ScW   = tlqv_pkg::PosW + 10;
   localparam int NumW  = tlqv_pkg::MapDW + tlqv_pkg::MapQW;
   localparam int LimW  = NumW - 1;

   // stage b: magnitude in Q17 plus half divisor
   logic [tlqv_pkg::MapDW-1:0] den_x;
   logic [tlqv_pkg::MapDW-1:0] den_y;
   logic [tlqv_pkg::PosW-1:0]  neg_px;
   logic [tlqv_pkg::PosW-1:0]  neg_py;
   logic [tlqv_pkg::PosW-1:0]  mag_x;
   logic [tlqv_pkg::PosW-1:0]  mag_y;
   logic                       b_valid_ff;
   logic [ScW-1:0]             b_mx_ff;
   logic [ScW-1:0]             b_my_ff;
   logic [tlqv_pkg::MapDW-1:0] b_dx_ff;
   logic [tlqv_pkg::MapDW-1:0] b_dy_ff;
   logic                       b_negx_ff;
   logic                       b_negy_ff;
   tlqv_pkg::tlqv_vtx_type     b_vtx_ff;

   assign den_x  = (canvas_width == '0)  ? tlqv_pkg::MapDW'(1) : canvas_width;
   assign den_y  = (canvas_height == '0) ? tlqv_pkg::MapDW'(1) : canvas_height;
   assign neg_px = -in_px;
   assign neg_py = -in_py;
   assign mag_x  = in_px[tlqv_pkg::PosW-1] ? neg_px : in_px;
   assign mag_y  = in_py[tlqv_pkg::PosW-1] ? neg_py : in_py;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_mx_ff   <= {1'b0, mag_x, 9'b0} + ScW'(den_x[tlqv_pkg::MapDW-1:1]);
         b_my_ff   <= {1'b0, mag_y, 9'b0} + ScW'(den_y[tlqv_pkg::MapDW-1:1]);
         b_dx_ff   <= den_x;
         b_dy_ff   <= den_y;
         b_negx_ff <= in_px[tlqv_pkg::PosW-1];
         b_negy_ff <= in_py[tlqv_pkg::PosW-1];
         b_vtx_ff  <= in_vtx;
      end
   end

   // stage c: clamp so the quotient never passes 2^21, far past saturation
   logic [LimW-1:0]            lim_x;
   logic [LimW-1:0]            lim_y;
   logic                       c_valid_ff;
   logic [NumW-1:0]            c_numx_ff;
   logic [NumW-1:0]            c_numy_ff;
   logic [tlqv_pkg::MapDW-1:0] c_dx_ff;
   logic [tlqv_pkg::MapDW-1:0] c_dy_ff;
   logic                       c_negx_ff;
   logic                       c_negy_ff;
   tlqv_pkg::tlqv_vtx_type     c_vtx_ff;

   assign lim_x = {b_dx_ff, {(tlqv_pkg::MapQW-1){1'b0}}};
   assign lim_y = {b_dy_ff, {(tlqv_pkg::MapQW-1){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_numx_ff <= (b_mx_ff >= ScW'(lim_x)) ? {1'b0, lim_x} : {1'b0, b_mx_ff[LimW-1:0]};
         c_numy_ff <= (b_my_ff >= ScW'(lim_y)) ? {1'b0, lim_y} : {1'b0, b_my_ff[LimW-1:0]};
         c_dx_ff   <= b_dx_ff;
         c_dy_ff   <= b_dy_ff;
         c_negx_ff <= b_negx_ff;
         c_negy_ff <= b_negy_ff;
         c_vtx_ff  <= b_vtx_ff;
      end
   end

   // mapping dividers
   logic                       dvx_valid;
   logic [tlqv_pkg::MapQW-1:0] dvx_quot;
   logic [VtxW:0]              dvx_tag;
   logic                       dvy_valid;
   logic [tlqv_pkg::MapQW-1:0] dvy_quot;
   logic                       dvy_tag;

   tlqv_div_pipe #(
      .DW (tlqv_pkg::MapDW),
      .QW (tlqv_pkg::MapQW),
      .TW (VtxW + 1)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_num    (c_numx_ff),
      .in_den    (c_dx_ff),
      .in_tag    ({c_vtx_ff, c_negx_ff}),
      .out_valid (dvx_valid),
      .out_quot  (dvx_quot),
      .out_tag   (dvx_tag)
   );

   tlqv_div_pipe #(
      .DW (tlqv_pkg::MapDW),
      .QW (tlqv_pkg::MapQW),
      .TW (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_num    (c_numy_ff),
      .in_den    (c_dy_ff),
      .in_tag    (c_negy_ff),
      .out_valid (dvy_valid),
      .out_quot  (dvy_quot),
      .out_tag   (dvy_tag)
   );

   // output stage: signed quotient, offset by one, saturate
   logic signed [24:0] qx_mag;
   logic signed [24:0] qy_mag;
   logic signed [24:0] qx;
   logic signed [24:0] qy;
   logic signed [24:0] full_x;
   logic signed [24:0] full_y;
   logic                             o_valid_ff;
   logic signed [tlqv_pkg::OutW-1:0] o_x_ff;
   logic signed [tlqv_pkg::OutW-1:0] o_y_ff;
   tlqv_pkg::tlqv_vtx_type           o_vtx_ff;

   assign qx_mag = $signed(25'(dvx_quot));
   assign qy_mag = $signed(25'(dvy_quot));
   assign qx     = dvx_tag[0] ? -qx_mag : qx_mag;
   assign qy     = dvy_tag ? -qy_mag : qy_mag;
   assign full_x = qx - tlqv_pkg::QOne;
   assign full_y = tlqv_pkg::QOne - qy;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= dvx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (full_x > tlqv_pkg::SatMax) begin
            o_x_ff <= tlqv_pkg::SatMax[tlqv_pkg::OutW-1:0];
         end else if (full_x < tlqv_pkg::SatMin) begin
            o_x_ff <= tlqv_pkg::SatMin[tlqv_pkg::OutW-1:0];
         end else begin
            o_x_ff <= full_x[tlqv_pkg::OutW-1:0];
         end
         if (full_y > tlqv_pkg::SatMax) begin
            o_y_ff <= tlqv_pkg::SatMax[tlqv_pkg::OutW-1:0];
         end else if (full_y < tlqv_pkg::SatMin) begin
            o_y_ff <= tlqv_pkg::SatMin[tlqv_pkg::OutW-1:0];
         end else begin
            o_y_ff <= full_y[tlqv_pkg::OutW-1:0];
         end
         o_vtx_ff <= dvx_tag[VtxW:1];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_x     = o_x_ff;
   assign out_y     = o_y_ff;
   assign out_vtx   = o_vtx_ff;

   // y divider runs in lockstep with x divider
   logic unused_dvy_valid;
   assign unused_dvy_valid = dvy_valid;

endmodule

// ===== rtl/thick_line_quad_vertex_generator.sv =====
// Expands one rectangle or thick-line request into six vertices (two triangles) in normalized
// device coordinates, one vertex per cycle on the result stream while rsp_tready does not stall it,
// with tlast on the sixth. The request side takes a new request while the sequencer is empty or
// sends its last corner, so several requests can be in flight at once in a front pipeline
// (multipliers, a 32-stage square root and two 28-stage offset dividers) that stalls while the
// sequencer is busy and feeds a six-step vertex sequencer. Each vertex then passes a corner
// register and a 25-stage mapping pipeline with two 22-stage dividers. canvas_width and
// canvas_height sit at byte addresses 0 and 4; the user must see that they are written only while
// no request is in flight, as the block itself does not enforce this. A value of zero acts as one.
module thick_line_quad_vertex_generator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // x_start[23:0], y_start[47:24], x_end[71:48], y_end[95:72], stroke_width[111:96],
   // color[143:112]
   input  logic [143:0] req_tdata,
   // command[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vertex_x[19:0], vertex_y[39:20], tex_x[59:40], tex_y[79:60], vertex_color[111:80],
   // vertex_index[114:112], zero fill[119:115]
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // configuration registers
   logic [tlqv_pkg::CfgW-1:0] width_ff;
   logic [tlqv_pkg::CfgW-1:0] height_ff;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tlqv_pkg::CanvasReset;
         height_ff <= tlqv_pkg::CanvasReset;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            tlqv_pkg::RegWidth: begin
               width_ff <= csr_pwdata[tlqv_pkg::CfgW-1:0];
            end
            tlqv_pkg::RegHeight: begin
               height_ff <= csr_pwdata[tlqv_pkg::CfgW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         tlqv_pkg::RegWidth:  csr_prdata = 32'(width_ff);
         tlqv_pkg::RegHeight: csr_prdata = 32'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // stall control: back half moves when the output register is free or taken
   logic en_b;
   logic en_f;
   logic ser_valid_ff;
   logic [tlqv_pkg::IdxW-1:0] ser_k_ff;
   tlqv_pkg::tlqv_quad_type   ser_quad_ff;

   assign en_b       = !rsp_tvalid || rsp_tready;
   assign en_f       = !ser_valid_ff || (en_b && ser_k_ff == tlqv_pkg::LastIdx);
   assign req_tready = en_f;

   // request unpack and offset pipeline
   tlqv_pkg::tlqv_prim_type req_prim;
   logic                    f_valid;
   tlqv_pkg::tlqv_quad_type f_quad;

   assign req_prim.cmd   = req_tuser[0];
   assign req_prim.x0    = req_tdata[23:0];
   assign req_prim.y0    = req_tdata[47:24];
   assign req_prim.x1    = req_tdata[71:48];
   assign req_prim.y1    = req_tdata[95:72];
   assign req_prim.color = req_tdata[143:112];

   tlqv_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .en        (en_f),
      .in_valid  (req_tvalid),
      .in_prim   (req_prim),
      .in_width  (req_tdata[111:96]),
      .out_valid (f_valid),
      .out_quad  (f_quad)
   );

   // vertex sequencer: holds one quad and steps through its six corners
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_k_ff     <= '0;
      end else if (en_f) begin
         ser_valid_ff <= f_valid;
         ser_k_ff     <= '0;
      end else if (en_b) begin
         ser_k_ff <= ser_k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         ser_quad_ff <= f_quad;
      end
   end

   // corner selection and offset
   logic                               end_x;
   logic                               end_y;
   logic                               minus;
   logic signed [tlqv_pkg::CoordW-1:0] base_x;
   logic signed [tlqv_pkg::CoordW-1:0] base_y;
   logic signed [tlqv_pkg::PosW-1:0]   ox_w;
   logic signed [tlqv_pkg::PosW-1:0]   oy_w;
   logic signed [tlqv_pkg::PosW-1:0]   px;
   logic signed [tlqv_pkg::PosW-1:0]   py;

   always_comb begin
      end_y = ser_k_ff inside {3'd2, 3'd4, 3'd5};
      if (ser_quad_ff.prim.cmd == tlqv_pkg::CmdLine) begin
         end_x = end_y;
      end else begin
         end_x = ser_k_ff[0];
      end
      minus  = !ser_k_ff[0];
      base_x = end_x ? ser_quad_ff.prim.x1 : ser_quad_ff.prim.x0;
      base_y = end_y ? ser_quad_ff.prim.y1 : ser_quad_ff.prim.y0;
      ox_w   = tlqv_pkg::PosW'(ser_quad_ff.ox);
      oy_w   = tlqv_pkg::PosW'(ser_quad_ff.oy);
      px     = tlqv_pkg::PosW'(base_x) + (minus ? -ox_w : ox_w);
      py     = tlqv_pkg::PosW'(base_y) + (minus ? oy_w : -oy_w);
   end

   logic                             a_valid_ff;
   logic signed [tlqv_pkg::PosW-1:0] a_px_ff;
   logic signed [tlqv_pkg::PosW-1:0] a_py_ff;
   tlqv_pkg::tlqv_vtx_type           a_vtx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_b) begin
         a_valid_ff <= ser_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         a_px_ff        <= px;
         a_py_ff        <= py;
         a_vtx_ff.color <= ser_quad_ff.prim.color;
         a_vtx_ff.idx   <= ser_k_ff;
      end
   end

   // coordinate mapping and output register
   logic signed [tlqv_pkg::OutW-1:0] vx;
   logic signed [tlqv_pkg::OutW-1:0] vy;
   tlqv_pkg::tlqv_vtx_type           vtx;

   tlqv_map u_map (
      .clock         (clock),
      .reset         (reset),
      .en            (en_b),
      .in_valid      (a_valid_ff),
      .in_px         (a_px_ff),
      .in_py         (a_py_ff),
      .in_vtx        (a_vtx_ff),
      .canvas_width  (width_ff),
      .canvas_height (height_ff),
      .out_valid     (rsp_tvalid),
      .out_x         (vx),
      .out_y         (vy),
      .out_vtx       (vtx)
   );

   assign rsp_tdata = {5'b0, vtx.idx, vtx.color, tlqv_pkg::TexY, tlqv_pkg::TexX, vy, vx};
   assign rsp_tlast = (vtx.idx == tlqv_pkg::LastIdx);

   // sequencer never counts past the sixth corner
   assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> ser_k_ff <= tlqv_pkg::LastIdx)
      else $error("vertex sequencer index out of range");

   // no request is taken while the sequencer still has corners to send
   assert property (@(posedge clock) disable iff (reset)
      (ser_valid_ff && ser_k_ff != tlqv_pkg::LastIdx) |-> !req_tready)
      else $error("request accepted while sequencer busy");

   // a held corner stays put while the back half is stalled
   assert property (@(posedge clock) disable iff (reset)
      (ser_valid_ff && ser_k_ff != tlqv_pkg::LastIdx && !en_b) |=> $stable(ser_k_ff))
      else $error("sequencer stepped during stall");

   // a vertex that enters the mapping pipe was issued by a busy sequencer
   assert property (@(posedge clock) disable iff (reset)
      (en_b && ser_valid_ff) |=> a_valid_ff && a_vtx_ff.idx == $past(ser_k_ff))
      else $error("vertex index lost between sequencer and mapping");

endmodule
